// File: hdl/mnsv_pkg.sv
`timescale 1ns / 1ps

package mnsv_pkg;

   localparam int VALVES_DEF    = 6;
   localparam int TICK_BITS_DEF = 32;

   // visible pins on the result channel
   localparam int PIN_BITS      = 6;
   localparam int BYTE_BITS     = 8;
   localparam int POS_BITS      = 7;
   // valve index wide enough for up to 16 valves
   localparam int IDX_BITS      = 4;

   localparam logic [BYTE_BITS-1:0] STATUS_NOTE_ON = 8'h90;
   localparam logic [BYTE_BITS-1:0] NOTE_VALVE0    = 8'h43;
   localparam logic [BYTE_BITS-1:0] NOTE_VALVE1    = 8'h45;
   localparam logic [BYTE_BITS-1:0] NOTE_VALVE2    = 8'h47;
   localparam logic [BYTE_BITS-1:0] NOTE_VALVE3    = 8'h48;
   localparam logic [BYTE_BITS-1:0] NOTE_VALVE4    = 8'h4A;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_NOTE     = 2'd2,
      PH_VELOCITY = 2'd3
   } phase_type;

   typedef struct packed {
      logic                valid;
      logic [IDX_BITS-1:0] idx;
      logic [POS_BITS-1:0] target;
   } move_type;

   typedef struct packed {
      logic                hit;
      logic [IDX_BITS-1:0] idx;
   } note_map_type;

   function automatic note_map_type note_to_valve(input logic [BYTE_BITS-1:0] note);
      note_map_type m;
      m.hit = 1'b1;
      m.idx = '0;
      case (note)
         NOTE_VALVE0: m.idx = IDX_BITS'(0);
         NOTE_VALVE1: m.idx = IDX_BITS'(1);
         NOTE_VALVE2: m.idx = IDX_BITS'(2);
         NOTE_VALVE3: m.idx = IDX_BITS'(3);
         NOTE_VALVE4: m.idx = IDX_BITS'(4);
         default:     m.hit = 1'b0;
      endcase
      return m;
   endfunction

endpackage

// File: hdl/mnsv_parser.sv
`timescale 1ns / 1ps

module mnsv_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_en,
   input  logic [7:0]                byte_data,
   output mnsv_pkg::move_type        move
);
   import mnsv_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [BYTE_BITS-1:0]   status_ff, status_in;
   logic [BYTE_BITS-1:0]   note_ff, note_in;
   note_map_type           map;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         status_ff <= '0;
         note_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         note_ff   <= note_in;
      end
   end

   // a status byte always restarts; there is no separate status phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_en) begin
         if (byte_data[7]) begin
            phase_in = PH_NOTE;
         end else begin
            unique case (phase_ff)
               PH_NOTE:     phase_in = PH_VELOCITY;
               PH_VELOCITY: phase_in = PH_IDLE;
               default:     phase_in = phase_ff;
            endcase
         end
      end
   end

   always_comb begin
      status_in   = status_ff;
      note_in     = note_ff;
      map         = note_to_valve(note_ff);
      move.valid  = 1'b0;
      move.idx    = map.idx;
      move.target = byte_data[POS_BITS-1:0];
      if (byte_en) begin
         if (byte_data[7]) begin
            status_in = byte_data;
         end else begin
            unique case (phase_ff)
               PH_NOTE:     note_in = byte_data;
               PH_VELOCITY: move.valid = map.hit && (status_ff == STATUS_NOTE_ON);
               default:     move.valid = 1'b0;
            endcase
         end
      end
   end

endmodule

// File: hdl/mnsv_valves.sv
`timescale 1ns / 1ps

module mnsv_valves #(
   parameter int VALVES    = mnsv_pkg::VALVES_DEF,
   parameter int TICK_BITS = mnsv_pkg::TICK_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                tick_en,
   input  mnsv_pkg::move_type  move,
   output logic [VALVES-1:0]   step_next,
   output logic [VALVES-1:0]   dir_next
);
   import mnsv_pkg::*;

   logic [POS_BITS-1:0]  pos_ff [VALVES];
   logic [POS_BITS-1:0]  pos_in [VALVES];
   logic [TICK_BITS-1:0] end_ff [VALVES];
   logic [TICK_BITS-1:0] end_in [VALVES];
   logic [VALVES-1:0]    armed_ff, armed_in;
   logic [VALVES-1:0]    step_ff, step_in;
   logic [VALVES-1:0]    dir_ff, dir_in;
   logic [TICK_BITS-1:0] count_ff, count_in;
   logic [POS_BITS-1:0]  distance;
   logic                 up;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VALVES; i++) begin
            pos_ff[i] <= '0;
            end_ff[i] <= '0;
         end
         armed_ff <= '0;
         step_ff  <= '0;
         dir_ff   <= '0;
         count_ff <= '0;
      end else begin
         for (int i = 0; i < VALVES; i++) begin
            pos_ff[i] <= pos_in[i];
            end_ff[i] <= end_in[i];
         end
         armed_ff <= armed_in;
         step_ff  <= step_in;
         dir_ff   <= dir_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      armed_in = armed_ff;
      step_in  = step_ff;
      dir_in   = dir_ff;
      count_in = count_ff;
      distance = '0;
      up       = 1'b0;
      for (int i = 0; i < VALVES; i++) begin
         pos_in[i] = pos_ff[i];
         end_in[i] = end_ff[i];
      end
      if (tick_en) begin
         for (int i = 0; i < VALVES; i++) begin
            if (end_ff[i] == count_ff) armed_in[i] = 1'b0;
         end
         step_in  = step_ff ^ armed_in;
         count_in = count_ff + TICK_BITS'(1);
      end else if (move.valid) begin
         for (int i = 0; i < VALVES; i++) begin
            if (move.idx == IDX_BITS'(i)) begin
               up        = move.target >= pos_ff[i];
               distance  = up ? (move.target - pos_ff[i]) : (pos_ff[i] - move.target);
               dir_in[i] = up;
               armed_in[i] = 1'b1;
               end_in[i] = count_ff + TICK_BITS'(distance);
               pos_in[i] = move.target;
            end
         end
      end
      step_next = step_in;
      dir_next  = dir_in;
   end

endmodule

// File: hdl/midi_note_to_stepper_valves_top.sv
`timescale 1ns / 1ps

// MIDI note-on to stepper valve driver. Each request is either a received MIDI
// byte (req_tuser = 0) or one step timer tick (req_tuser = 1), and each
// request yields exactly one response carrying the step and direction pin
// levels after that request took effect. A note-on (status 0x90) for notes
// 0x43, 0x45, 0x47, 0x48, 0x4A moves valves 0..4 to the velocity position:
// direction is set, the valve is armed and its end tick is count plus
// distance; ticks toggle armed step pins and disarm valves that reached their
// end tick. There is no running status; data bytes while idle are dropped.
// Throughput is one request per clock while responses are taken; a request
// passes the input register, then the response register. The parser and the
// valve registers update in a single pass as the request moves into the
// response register, so a stalled response only holds the pipe when both fill.

module midi_note_to_stepper_valves_top #(
   parameter int VALVES    = mnsv_pkg::VALVES_DEF,
   parameter int TICK_BITS = mnsv_pkg::TICK_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] midi_byte
   input  logic [0:0]  req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [5:0] step_pins, [11:6] dir_pins, [15:12] zero
);
   import mnsv_pkg::*;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_op_ff;
   logic [BYTE_BITS-1:0] in_byte_ff;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIN_BITS-1:0]  step_pins_ff, dir_pins_ff;

   logic                 req_fire;
   logic                 advance;
   logic                 work_en;
   move_type             move;
   logic [VALVES-1:0]    step_next, dir_next;
   logic [VALVES+PIN_BITS-1:0] step_ext, dir_ext;

   // the response register frees up when empty or taken this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign work_en    = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (work_en)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff   <= req_tuser[0];
         in_byte_ff <= req_tdata;
      end
      if (work_en) begin
         step_pins_ff <= step_ext[PIN_BITS-1:0];
         dir_pins_ff  <= dir_ext[PIN_BITS-1:0];
      end
   end

   mnsv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (work_en && !in_op_ff),
      .byte_data (in_byte_ff),
      .move      (move)
   );

   mnsv_valves #(
      .VALVES    (VALVES),
      .TICK_BITS (TICK_BITS)
   ) u_valves (
      .clock     (clock),
      .reset     (reset),
      .tick_en   (work_en && in_op_ff),
      .move      (move),
      .step_next (step_next),
      .dir_next  (dir_next)
   );

   // pins beyond the valve count read zero; valves beyond the pins are hidden
   assign step_ext = {{PIN_BITS{1'b0}}, step_next};
   assign dir_ext  = {{PIN_BITS{1'b0}}, dir_next};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, dir_pins_ff, step_pins_ff};

endmodule

// File: hdl/mnsv_checker.sv
`timescale 1ns / 1ps

module mnsv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a held response keeps its pins
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // an accepted request reaches the response register when the consumer is taking
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] == 4'b0000)
      else $error("response padding not zero");

endmodule

bind midi_note_to_stepper_valves_top mnsv_checker u_mnsv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/midi_note_to_stepper_valves_top_test.sv
`timescale 1ns / 1ps

module midi_note_to_stepper_valves_top_test;

   import mnsv_pkg::*;

   localparam int VALVE_COUNT = VALVES_DEF;
   localparam int TICK_WIDTH  = TICK_BITS_DEF;

   // request kinds carried in req_tuser
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam int RANDOM_REQUESTS = 1850;
   // worst case: ~1850 requests, each with the longest gap and the longest stall
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 8;

   // one response: pin levels after a request took effect
   typedef struct packed {
      logic [PIN_BITS-1:0] dir_pins;
      logic [PIN_BITS-1:0] step_pins;
   } pin_levels_type;

   // Tracks parser and valve state, and the pin levels owed to the response side.
   class valve_pin_tracker_type;
      phase_type             phase;
      logic [BYTE_BITS-1:0]  status;
      logic [BYTE_BITS-1:0]  note;
      logic [POS_BITS-1:0]   position [VALVE_COUNT];
      logic [TICK_WIDTH-1:0] end_tick [VALVE_COUNT];
      logic [VALVE_COUNT-1:0] armed;
      logic [VALVE_COUNT-1:0] steps;
      logic [VALVE_COUNT-1:0] dirs;
      logic [TICK_WIDTH-1:0] ticks;
      pin_levels_type        pending_pins [$];

      function new();
         phase  = PH_IDLE;
         status = '0;
         note   = '0;
         for (int i = 0; i < VALVE_COUNT; i++) begin
            position[i] = '0;
            end_tick[i] = '0;
         end
         armed = '0;
         steps = '0;
         dirs  = '0;
         ticks = '0;
      endfunction

      function void move_valve(int idx, logic [POS_BITS-1:0] target);
         logic [POS_BITS-1:0] distance;
         if (idx >= VALVE_COUNT) return;
         if (target < position[idx]) begin
            dirs[idx] = 1'b0;
            distance = position[idx] - target;
         end else begin
            // equal target counts as upward: zero-length move still arms
            dirs[idx] = 1'b1;
            distance = target - position[idx];
         end
         end_tick[idx] = ticks + TICK_WIDTH'(distance);
         armed[idx]    = 1'b1;
         position[idx] = target;
      endfunction

      function void finish_message(logic [BYTE_BITS-1:0] velocity);
         if (status != STATUS_NOTE_ON) return;
         case (note)
            NOTE_VALVE0: move_valve(0, velocity[POS_BITS-1:0]);
            NOTE_VALVE1: move_valve(1, velocity[POS_BITS-1:0]);
            NOTE_VALVE2: move_valve(2, velocity[POS_BITS-1:0]);
            NOTE_VALVE3: move_valve(3, velocity[POS_BITS-1:0]);
            NOTE_VALVE4: move_valve(4, velocity[POS_BITS-1:0]);
            default: ;
         endcase
      endfunction

      // note an accepted request and queue the pin levels it should produce
      function void take_request(logic op, logic [BYTE_BITS-1:0] b);
         pin_levels_type lv;
         if (op == OP_TICK) begin
            // disarm before toggling, so a valve due now does not step
            for (int i = 0; i < VALVE_COUNT; i++)
               if (end_tick[i] == ticks) armed[i] = 1'b0;
            steps = steps ^ armed;
            ticks = ticks + 1'b1;
         end else if (b[BYTE_BITS-1]) begin
            // any status byte restarts the parser, no running status
            status = b;
            phase  = PH_NOTE;
         end else begin
            case (phase)
               PH_NOTE: begin
                  note  = b;
                  phase = PH_VELOCITY;
               end
               PH_VELOCITY: begin
                  phase = PH_IDLE;
                  finish_message(b);
               end
               default: ;
            endcase
         end
         lv.step_pins = steps[PIN_BITS-1:0];
         lv.dir_pins  = dirs[PIN_BITS-1:0];
         pending_pins.push_back(lv);
      endfunction

      // returns 1 on mismatch or an unexpected response, with a one-line description
      function bit check_pins(logic [15:0] data, output string why);
         pin_levels_type want;
         logic [PIN_BITS-1:0] got_step;
         logic [PIN_BITS-1:0] got_dir;
         got_step = data[PIN_BITS-1:0];
         got_dir  = data[2*PIN_BITS-1:PIN_BITS];
         why = "";
         if (pending_pins.size() == 0) begin
            $sformat(why, "response %h with no request outstanding", data);
            return 1'b1;
         end
         want = pending_pins.pop_front();
         if (got_step != want.step_pins || got_dir != want.dir_pins) begin
            $sformat(why, "step_pins got %h want %h, dir_pins got %h want %h",
                     got_step, want.step_pins, got_dir, want.dir_pins);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function int outstanding();
         return pending_pins.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;

   valve_pin_tracker_type tracker;
   int  error_count;
   int  cycle_count;
   int  request_count;
   int  stall_left;
   bit  no_idle;      // when set, both sides run at full rate
   string why;

   midi_note_to_stepper_valves_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // present one request, hold it until accepted, then maybe idle
   task automatic send_request(logic op, logic [7:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      tracker.take_request(op, b);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         // scramble idle data so the block must ignore it
         req_tdata  <= 8'($urandom);
         req_tuser  <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_byte(logic [7:0] b);
      send_request(OP_BYTE, b);
   endtask

   task automatic send_tick();
      send_request(OP_TICK, 8'($urandom));
   endtask

   task automatic send_note_on(logic [7:0] note_b, logic [7:0] velocity);
      send_byte(STATUS_NOTE_ON);
      send_byte(note_b);
      send_byte(velocity);
      request_count += 3;
   endtask

   function automatic logic [7:0] pick_valve_note();
      case ($urandom_range(0, 4))
         0: return NOTE_VALVE0;
         1: return NOTE_VALVE1;
         2: return NOTE_VALVE2;
         3: return NOTE_VALVE3;
         default: return NOTE_VALVE4;
      endcase
   endfunction

   function automatic logic [7:0] pick_velocity();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'h7F;
      return 8'($urandom_range(0, 127));
   endfunction

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("midi_note_to_stepper_valves_top_test: done, errors");
         $finish;
      end
   end

   // response side: check each accepted response, then pick the next tready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tracker.check_pins(rsp_tdata, why)) report_mismatch(why);
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   initial begin
      int r;
      int n;
      logic [7:0] b;
      tracker       = new();
      error_count   = 0;
      cycle_count   = 0;
      request_count = 0;
      stall_left    = 0;
      no_idle       = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_BYTE;
      rsp_tready    = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // data bytes while idle are ignored
      send_byte(8'h00);
      send_byte(8'h7F);
      // tick with nothing armed
      send_tick();
      // full upward move on valve 0
      send_note_on(NOTE_VALVE0, 8'h7F);
      // zero distance on valve 1: armed, then disarmed on the next tick
      send_note_on(NOTE_VALVE1, 8'h00);
      send_tick();
      send_note_on(NOTE_VALVE2, 8'h30);
      // status byte mid-message drops the partial one; other status has no effect
      send_byte(STATUS_NOTE_ON);
      send_byte(NOTE_VALVE3);
      send_byte(8'hFF);
      send_byte(NOTE_VALVE4);
      send_byte(8'h10);
      // note that maps to no valve
      send_note_on(8'h44, 8'h20);
      // downward move on valve 0
      send_note_on(NOTE_VALVE0, 8'h05);
      send_note_on(NOTE_VALVE3, 8'h7F);
      send_note_on(NOTE_VALVE4, 8'h01);
      send_tick();

      // ---- random part ----
      request_count = 0;
      while (request_count < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 99) < 4) no_idle = ~no_idle;
         r = $urandom_range(0, 99);
         if (r < 45) begin
            // well-formed note-on, mostly to a mapped note
            if ($urandom_range(0, 9) != 0) b = pick_valve_note();
            else b = 8'($urandom_range(0, 127));
            send_note_on(b, pick_velocity());
         end else if (r < 80) begin
            // tick bursts, now and then long enough to finish big moves
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 8);
            repeat (n) send_tick();
            request_count += n;
         end else if (r < 88) begin
            // truncated message, the next status byte drops it
            send_byte(8'($urandom_range(128, 255)));
            request_count++;
            if ($urandom_range(0, 1)) begin
               send_byte(8'($urandom_range(0, 127)));
               request_count++;
            end
         end else if (r < 95) begin
            // complete message with arbitrary status and note
            send_byte(8'($urandom_range(128, 255)));
            send_byte(8'($urandom_range(0, 127)));
            send_byte(8'($urandom_range(0, 127)));
            request_count += 3;
         end else begin
            // stray data byte; ignored when idle, so not counted
            send_byte(8'($urandom_range(0, 127)));
         end
      end

      // ---- drain ----
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("midi_note_to_stepper_valves_top_test: done, clean");
      else
         $display("midi_note_to_stepper_valves_top_test: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
hdl/mnsv_pkg.sv
hdl/mnsv_parser.sv
hdl/mnsv_valves.sv
hdl/midi_note_to_stepper_valves_top.sv
hdl/mnsv_checker.sv
tb/midi_note_to_stepper_valves_top_test.sv
